FILE: src/sset_pkg.sv
`timescale 1ns / 1ps
package sset_pkg;

    localparam int RETRY_BITS_DEF = 64;
    localparam int RETRY_W        = 64;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [3:0] TK_EVENT_BEGIN = 4'd0;
    localparam logic [3:0] TK_EVENT_BYTE  = 4'd1;
    localparam logic [3:0] TK_DATA_BEGIN  = 4'd2;
    localparam logic [3:0] TK_DATA_BYTE   = 4'd3;
    localparam logic [3:0] TK_ID_BEGIN    = 4'd4;
    localparam logic [3:0] TK_ID_BYTE     = 4'd5;
    localparam logic [3:0] TK_ID_END      = 4'd6;
    localparam logic [3:0] TK_DISPATCH    = 4'd7;
    localparam logic [3:0] TK_CLEAR       = 4'd8;

    localparam logic [2:0] FLD_EVENT = 3'd0;
    localparam logic [2:0] FLD_DATA  = 3'd1;
    localparam logic [2:0] FLD_ID    = 3'd2;
    localparam logic [2:0] FLD_RETRY = 3'd3;
    localparam logic [2:0] FLD_NONE  = 3'd4;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_START,
        PH_NAME,
        PH_SKIP,
        PH_VALUE
    } t_phase;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
        logic       flag;
        logic       rp;
    } t_token;

    typedef struct packed {
        logic                 two;
        t_token               tok0;
        t_token               tok1;
        logic [RETRY_W-1:0]   retry;
    } t_entry;

    function automatic logic [7:0] bom_byte(input logic [1:0] i);
        case (i)
            2'd0:    return 8'hEF;
            2'd1:    return 8'hBB;
            default: return 8'hBF;
        endcase
    endfunction

    function automatic logic [2:0] name_len(input logic [1:0] c);
        case (c)
            2'd0:    return 3'd5;
            2'd1:    return 3'd4;
            2'd2:    return 3'd2;
            default: return 3'd5;
        endcase
    endfunction

    function automatic logic [7:0] name_char(input logic [1:0] c, input logic [2:0] p);
        logic [39:0] s;
        case (c)
            2'd0:    s = "event";
            2'd1:    s = {"data", 8'h00};
            2'd2:    s = {"id", 24'h0};
            default: s = "retry";
        endcase
        case (p)
            3'd0:    return s[39:32];
            3'd1:    return s[31:24];
            3'd2:    return s[23:16];
            3'd3:    return s[15:8];
            3'd4:    return s[7:0];
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [2:0] match_field(input logic [3:0] cand, input logic [2:0] pos);
        logic [2:0] f;
        f = FLD_NONE;
        for (int c = 3; c >= 0; c--) begin
            if (cand[c] && name_len(2'(c)) == pos) f = 3'(c);
        end
        return f;
    endfunction

    function automatic logic [3:0] name_step(input logic [3:0] cand, input logic [2:0] pos,
                                             input logic [7:0] b);
        logic [3:0] r;
        r = cand;
        for (int c = 0; c < 4; c++) begin
            if (pos >= name_len(2'(c)) || name_char(2'(c), pos) != b) r[c] = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: src/sset_byte_if.sv
`timescale 1ns / 1ps
interface sset_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

FILE: src/sset_tok_if.sv
`timescale 1ns / 1ps
interface sset_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  token_byte;
    logic        token_flag;
    logic        retry_present;
    logic [63:0] retry_value;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_byte, output token_flag,
                    output retry_present, output retry_value, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input token_byte, input token_flag,
                  input retry_present, input retry_value, input last_of_run,
                  output ready);
endinterface

FILE: src/sset_front.sv
`timescale 1ns / 1ps
module sset_front #(
    parameter int RETRY_BITS = sset_pkg::RETRY_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sset_byte_if.sink        i_req,
    input  logic             i_full,
    output logic             o_push,
    output sset_pkg::t_entry o_entry
);
    import sset_pkg::*;

    logic                  r_start, n_start;
    logic [1:0]            r_bom, n_bom;
    logic                  r_cr, n_cr;
    t_phase                r_phase, n_phase;
    logic [2:0]            r_pos, n_pos;
    logic [3:0]            r_cand, n_cand;
    logic                  r_first, n_first;
    logic                  r_nul, n_nul;
    logic [RETRY_BITS-1:0] r_acc, n_acc;
    logic [2:0]            r_rflags, n_rflags;
    logic [RETRY_BITS-1:0] r_held, n_held;
    logic                  r_hvalid, n_hvalid;
    logic                  r_data, n_data;
    logic                  r_evne, n_evne;
    logic [1:0]            r_vfield, n_vfield;

    logic                  w_acc_ok;
    logic                  w_skip;
    t_phase                w_ph;
    logic [2:0]            w_pos;
    logic [3:0]            w_cand;
    logic [2:0]            w_f;
    logic [1:0]            w_ntok;
    t_token                w_t0, w_t1;
    logic [RETRY_W-1:0]    w_rv;
    logic [RETRY_BITS+3:0] w_prod;
    logic [7:0]            b;

    assign b        = i_req.stream_byte;
    assign i_req.ready = !i_full;
    assign w_acc_ok = i_req.valid && !i_full;
    // acc*10 + digit, the top four bits flag overflow
    assign w_prod = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                  + (RETRY_BITS+4)'(b - CH_ZERO);

    always_comb begin
        n_start = r_start; n_bom = r_bom; n_cr = r_cr; n_phase = r_phase;
        n_pos = r_pos; n_cand = r_cand; n_first = r_first; n_nul = r_nul;
        n_acc = r_acc; n_rflags = r_rflags; n_held = r_held; n_hvalid = r_hvalid;
        n_data = r_data; n_evne = r_evne; n_vfield = r_vfield;
        w_skip = 1'b0; w_ph = r_phase; w_pos = r_pos; w_cand = r_cand;
        w_f = FLD_NONE; w_ntok = 2'd0; w_t0 = '0; w_t1 = '0; w_rv = '0;

        if (r_start) begin
            n_start = 1'b0;
            n_bom   = 2'd0;
            if (b == bom_byte(r_bom)) begin
                w_skip = 1'b1;
                if (r_bom != 2'd2) begin
                    n_start = 1'b1;
                    n_bom   = r_bom + 2'd1;
                end
            end else if (r_bom != 2'd0) begin
                // held mark bytes open a name that matches nothing
                w_ph   = PH_NAME;
                w_cand = 4'h0;
                w_pos  = {1'b0, r_bom};
            end
        end

        if (!w_skip) begin
            if (b == CH_CR || b == CH_LF) begin
                if (r_cr && b == CH_LF) begin
                    n_cr = 1'b0;
                end else begin
                    n_cr = (b == CH_CR);
                    case (w_ph)
                        PH_START: begin
                            if (r_data) begin
                                w_t0   = '{TK_DISPATCH, 8'h00, r_evne, r_hvalid};
                                w_t1   = '{TK_CLEAR, 8'h00, 1'b0, 1'b0};
                                w_rv   = r_hvalid ? RETRY_W'(r_held) : '0;
                                w_ntok = 2'd2;
                            end else begin
                                w_t0   = '{TK_CLEAR, 8'h00, 1'b0, 1'b0};
                                w_ntok = 2'd1;
                            end
                            n_evne = 1'b0; n_data = 1'b0;
                            n_held = '0;   n_hvalid = 1'b0;
                        end
                        PH_NAME: begin
                            w_f = match_field(w_cand, w_pos);
                            case (w_f)
                                FLD_EVENT: begin
                                    n_evne = 1'b0;
                                    w_t0   = '{TK_EVENT_BEGIN, 8'h00, 1'b0, 1'b0};
                                    w_ntok = 2'd1;
                                end
                                FLD_DATA: begin
                                    w_t0   = '{TK_DATA_BEGIN, 8'h00, r_data, 1'b0};
                                    w_ntok = 2'd1;
                                    n_data = 1'b1;
                                end
                                FLD_ID: begin
                                    n_nul  = 1'b0;
                                    w_t0   = '{TK_ID_BEGIN, 8'h00, 1'b0, 1'b0};
                                    w_t1   = '{TK_ID_END, 8'h00, 1'b1, 1'b0};
                                    w_ntok = 2'd2;
                                end
                                default: ;
                            endcase
                        end
                        PH_VALUE: begin
                            if (r_vfield == FLD_ID[1:0]) begin
                                w_t0   = '{TK_ID_END, 8'h00, !r_nul, 1'b0};
                                w_ntok = 2'd1;
                            end else if (r_vfield == FLD_RETRY[1:0] &&
                                         r_rflags[1:0] == 2'b01) begin
                                n_held   = r_rflags[2] ? '0 : r_acc;
                                n_hvalid = !r_rflags[2];
                            end
                        end
                        default: ;
                    endcase
                    n_phase = PH_START;
                    n_pos   = 3'd0;
                    n_cand  = 4'hF;
                    n_first = 1'b0;
                end
            end else begin
                n_cr = 1'b0;
                case (w_ph)
                    PH_START: begin
                        if (b == CH_COLON) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase = PH_NAME;
                            n_cand  = name_step(4'hF, 3'd0, b);
                            n_pos   = 3'd1;
                        end
                    end
                    PH_NAME: begin
                        if (b != CH_COLON) begin
                            n_phase = PH_NAME;
                            n_cand  = name_step(w_cand, w_pos, b);
                            n_pos   = (w_pos != 3'd7) ? w_pos + 3'd1 : w_pos;
                        end else begin
                            w_f = match_field(w_cand, w_pos);
                            n_phase  = PH_VALUE;
                            n_first  = 1'b1;
                            n_vfield = w_f[1:0];
                            case (w_f)
                                FLD_EVENT: begin
                                    n_evne = 1'b0;
                                    w_t0   = '{TK_EVENT_BEGIN, 8'h00, 1'b0, 1'b0};
                                    w_ntok = 2'd1;
                                end
                                FLD_DATA: begin
                                    w_t0   = '{TK_DATA_BEGIN, 8'h00, r_data, 1'b0};
                                    w_ntok = 2'd1;
                                    n_data = 1'b1;
                                end
                                FLD_ID: begin
                                    n_nul  = 1'b0;
                                    w_t0   = '{TK_ID_BEGIN, 8'h00, 1'b0, 1'b0};
                                    w_ntok = 2'd1;
                                end
                                FLD_RETRY: begin
                                    n_acc    = '0;
                                    n_rflags = 3'b000;
                                end
                                default: begin
                                    n_phase  = PH_SKIP;
                                    n_first  = r_first;
                                    n_vfield = r_vfield;
                                end
                            endcase
                        end
                    end
                    PH_VALUE: begin
                        n_first = 1'b0;
                        if (!(r_first && b == CH_SPACE)) begin
                            case (r_vfield)
                                FLD_EVENT[1:0]: begin
                                    n_evne = 1'b1;
                                    w_t0   = '{TK_EVENT_BYTE, b, 1'b0, 1'b0};
                                    w_ntok = 2'd1;
                                end
                                FLD_DATA[1:0]: begin
                                    w_t0   = '{TK_DATA_BYTE, b, 1'b0, 1'b0};
                                    w_ntok = 2'd1;
                                end
                                FLD_ID[1:0]: begin
                                    if (b == 8'h00) n_nul = 1'b1;
                                    w_t0   = '{TK_ID_BYTE, b, 1'b0, 1'b0};
                                    w_ntok = 2'd1;
                                end
                                default: begin
                                    n_rflags[0] = 1'b1;
                                    if (b < CH_ZERO || b > CH_NINE) begin
                                        n_rflags[1] = 1'b1;
                                    end else if (!r_rflags[2]) begin
                                        if (|w_prod[RETRY_BITS+3:RETRY_BITS])
                                            n_rflags[2] = 1'b1;
                                        else
                                            n_acc = w_prod[RETRY_BITS-1:0];
                                    end
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_push        = w_acc_ok && (w_ntok != 2'd0);
    assign o_entry.two   = (w_ntok == 2'd2);
    assign o_entry.tok0  = w_t0;
    assign o_entry.tok1  = w_t1;
    assign o_entry.retry = w_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1; r_bom <= 2'd0; r_cr <= 1'b0; r_phase <= PH_START;
            r_pos <= 3'd0; r_cand <= 4'hF; r_first <= 1'b0; r_nul <= 1'b0;
            r_acc <= '0; r_rflags <= 3'b000; r_held <= '0; r_hvalid <= 1'b0;
            r_data <= 1'b0; r_evne <= 1'b0; r_vfield <= 2'd0;
        end else if (w_acc_ok) begin
            r_start <= n_start; r_bom <= n_bom; r_cr <= n_cr; r_phase <= n_phase;
            r_pos <= n_pos; r_cand <= n_cand; r_first <= n_first; r_nul <= n_nul;
            r_acc <= n_acc; r_rflags <= n_rflags; r_held <= n_held; r_hvalid <= n_hvalid;
            r_data <= n_data; r_evne <= n_evne; r_vfield <= n_vfield;
        end
    end
endmodule

FILE: src/sset_fifo.sv
`timescale 1ns / 1ps
module sset_fifo #(
    parameter int DEPTH = sset_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sset_pkg::t_entry i_entry,
    input  logic             i_pop,
    output sset_pkg::t_entry o_head,
    output logic             o_full,
    output logic             o_empty
);
    import sset_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (i_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("queue count out of range");
endmodule

FILE: src/sset_back.sv
`timescale 1ns / 1ps
module sset_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  sset_pkg::t_entry i_head,
    output logic             o_pop,
    sset_tok_if.source       o_tok
);
    import sset_pkg::*;

    logic   r_sub;
    logic   r_valid;
    t_token r_tok;
    logic   r_last;
    logic [RETRY_W-1:0] r_rv;

    logic   w_load, w_last;
    t_token w_tok;

    assign w_tok  = r_sub ? i_head.tok1 : i_head.tok0;
    assign w_last = r_sub || !i_head.two;
    assign w_load = !i_empty && (!r_valid || o_tok.ready);
    assign o_pop  = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_sub   <= !w_last;
                r_valid <= 1'b1;
            end else if (o_tok.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tok  <= w_tok;
            r_last <= w_last;
            r_rv   <= (w_tok.kind == TK_DISPATCH) ? i_head.retry : '0;
        end
    end

    assign o_tok.valid         = r_valid;
    assign o_tok.token_kind    = r_tok.kind;
    assign o_tok.token_byte    = r_tok.data;
    assign o_tok.token_flag    = r_tok.flag;
    assign o_tok.retry_present = r_tok.rp;
    assign o_tok.retry_value   = r_rv;
    assign o_tok.last_of_run   = r_last;
endmodule

FILE: src/sse_event_stream_tokenizer_core.sv
`timescale 1ns / 1ps
// Event stream tokenizer.
// i_req carries one raw stream byte per request (valid/ready). o_tok carries
// tagged tokens (valid/ready); last_of_run marks the final token caused by
// one input byte. Bytes that cause no token produce nothing on o_tok.
// The front parser takes one byte per cycle while the queue is not full and
// classifies it in that cycle; the tokens of a byte (up to two) go as one
// entry into a four-entry queue. The back end drains one token per cycle
// into an output register while the receiver is ready. Each entry is
// written into the queue as its byte is accepted; the output register
// then loads its tokens from the queue head.
// Throughput: one byte per cycle while bytes cause at most one token and the
// receiver is ready; the back end sends the two tokens of a byte one after
// the other, and the queue absorbs short bursts of such bytes.
// When the receiver stalls, the output register holds its token, the queue
// fills, and i_req.ready drops once the queue is full.
// Synchronous reset clears parser state (start of stream, no event, no
// retry) and empties the queue and the output register.
module sse_event_stream_tokenizer_core #(
    parameter int RETRY_BITS = sset_pkg::RETRY_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sset_byte_if.sink  i_req,
    sset_tok_if.source o_tok
);
    import sset_pkg::*;

    logic   w_push, w_pop, w_full, w_empty;
    t_entry w_entry, w_head;

    sset_front #(.RETRY_BITS(RETRY_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    sset_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    sset_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_tok   (o_tok)
    );
endmodule

FILE: sim/sse_event_stream_tokenizer_core_test.sv
`timescale 1ns / 1ps
module sse_event_stream_tokenizer_core_test;
    import sset_pkg::*;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  tbyte;
        logic        flag;
        logic        rp;
        logic [63:0] rv;
        logic        last;
    } t_tok_exp;

    class token_scoreboard;
        t_tok_exp pending[$];
        int errors;
        int checked;
        // tokenizer state
        bit at_start = 1;
        int bom_cnt;
        bit after_cr;
        t_phase phase = PH_START;
        int name_pos;
        bit [3:0] cand = 4'hF;
        bit first_val;
        bit id_nul;
        bit [63:0] racc;
        bit [2:0] rflags;
        bit [63:0] rheld;
        bit rheld_ok;
        bit data_seen;
        bit ev_nonempty;
        logic [2:0] vfield = FLD_NONE;
        t_tok_exp step_toks[$];

        function void push(logic [3:0] k, logic [7:0] b, bit f, bit rp, bit [63:0] rv);
            t_tok_exp t;
            t = '{kind: k, tbyte: b, flag: f, rp: rp, rv: rv, last: 1'b0};
            step_toks = {step_toks, t};
        endfunction

        function logic [2:0] field_hit();
            int lens[4];
            lens = '{5, 4, 2, 5};
            for (int c = 0; c < 4; c++)
                if (cand[c] && lens[c] == name_pos) return 3'(c);
            return FLD_NONE;
        endfunction

        function void open_field(logic [2:0] f);
            case (f)
                FLD_EVENT: begin ev_nonempty = 0; push(TK_EVENT_BEGIN, 0, 0, 0, 0); end
                FLD_DATA: begin push(TK_DATA_BEGIN, 0, data_seen, 0, 0); data_seen = 1; end
                FLD_ID: begin id_nul = 0; push(TK_ID_BEGIN, 0, 0, 0, 0); end
                FLD_RETRY: begin racc = 0; rflags = 0; end
                default: ;
            endcase
        endfunction

        function void value_char(logic [7:0] b);
            bit [63:0] d;
            if (first_val && b == CH_SPACE) begin first_val = 0; return; end
            first_val = 0;
            case (vfield)
                FLD_EVENT: begin ev_nonempty = 1; push(TK_EVENT_BYTE, b, 0, 0, 0); end
                FLD_DATA: push(TK_DATA_BYTE, b, 0, 0, 0);
                FLD_ID: begin if (b == 0) id_nul = 1; push(TK_ID_BYTE, b, 0, 0, 0); end
                FLD_RETRY: begin
                    rflags[0] = 1;
                    if (b < CH_ZERO || b > CH_NINE) rflags[1] = 1;
                    else if (!rflags[2]) begin
                        d = 64'(b - CH_ZERO);
                        if (racc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) rflags[2] = 1;
                        else racc = racc * 10 + d;
                    end
                end
                default: ;
            endcase
        endfunction

        function void close_line();
            logic [2:0] f;
            if (phase == PH_START) begin
                if (data_seen)
                    push(TK_DISPATCH, 0, ev_nonempty, rheld_ok, rheld_ok ? rheld : 0);
                push(TK_CLEAR, 0, 0, 0, 0);
                ev_nonempty = 0; data_seen = 0; rheld = 0; rheld_ok = 0;
            end else if (phase == PH_NAME) begin
                f = field_hit();
                if (f != FLD_RETRY) open_field(f);
                if (f == FLD_ID) push(TK_ID_END, 0, 1, 0, 0);
            end else if (phase == PH_VALUE) begin
                if (vfield == FLD_ID) push(TK_ID_END, 0, !id_nul, 0, 0);
                else if (vfield == FLD_RETRY && rflags[1:0] == 2'b01) begin
                    if (rflags[2]) begin rheld = 0; rheld_ok = 0; end
                    else begin rheld = racc; rheld_ok = 1; end
                end
            end
            phase = PH_START; name_pos = 0; cand = 4'hF; first_val = 0; vfield = FLD_NONE;
        endfunction

        function void name_char_in(logic [7:0] b);
            string nm[4];
            nm = '{"event", "data", "id", "retry"};
            for (int c = 0; c < 4; c++)
                if (cand[c] && (name_pos >= nm[c].len() || nm[c][name_pos] != b))
                    cand[c] = 0;
            if (name_pos < 7) name_pos++;
        endfunction

        function void line_char(logic [7:0] b);
            logic [2:0] f;
            if (b == CH_CR || b == CH_LF) begin
                if (after_cr && b == CH_LF) begin after_cr = 0; return; end
                after_cr = (b == CH_CR);
                close_line();
                return;
            end
            after_cr = 0;
            case (phase)
                PH_START: begin
                    if (b == CH_COLON) phase = PH_SKIP;
                    else begin phase = PH_NAME; name_char_in(b); end
                end
                PH_NAME: begin
                    if (b != CH_COLON) name_char_in(b);
                    else begin
                        f = field_hit();
                        if (f == FLD_NONE) phase = PH_SKIP;
                        else begin
                            open_field(f); vfield = f; first_val = 1; phase = PH_VALUE;
                        end
                    end
                end
                PH_VALUE: value_char(b);
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b);
            logic [7:0] bom[3];
            int held;
            bom = '{8'hEF, 8'hBB, 8'hBF};
            step_toks.delete();
            if (at_start) begin
                if (bom_cnt < 3 && b == bom[bom_cnt]) begin
                    bom_cnt++;
                    if (bom_cnt == 3) begin at_start = 0; bom_cnt = 0; end
                    return;
                end
                held = bom_cnt;
                at_start = 0; bom_cnt = 0;
                for (int k = 0; k < held; k++) line_char(bom[k]);
            end
            line_char(b);
            if (step_toks.size() > 0) step_toks[$].last = 1;
            pending = {pending, step_toks};
        endfunction

        function void check_token(t_tok_exp got);
            t_tok_exp e;
            if (pending.size() == 0) begin
                $error("token with nothing expected: kind %0d", got.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.kind !== e.kind) begin
                $error("token_kind exp %0d got %0d", e.kind, got.kind); errors++;
            end
            if (got.tbyte !== e.tbyte) begin
                $error("token_byte exp %h got %h", e.tbyte, got.tbyte); errors++;
            end
            if (got.flag !== e.flag) begin
                $error("token_flag exp %b got %b", e.flag, got.flag); errors++;
            end
            if (got.rp !== e.rp) begin
                $error("retry_present exp %b got %b", e.rp, got.rp); errors++;
            end
            if (got.rv !== e.rv) begin
                $error("retry_value exp %0d got %0d", e.rv, got.rv); errors++;
            end
            if (got.last !== e.last) begin
                $error("last_of_run exp %b got %b", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    sset_byte_if req_if ();
    sset_tok_if tok_if ();
    token_scoreboard sb;

    logic [7:0] stim[$];
    int requests_sent;
    bit hold_off_rx;
    bit stall_pause_done;

    sse_event_stream_tokenizer_core u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_if.sink),
        .o_tok(tok_if.source)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("sse_event_stream_tokenizer_core_test NOT OK");
        $finish;
    end

    task automatic add_byte(logic [7:0] b);
        stim = {stim, b};
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    function automatic string rand_eol();
        case ($urandom_range(0, 2))
            0: return "\n";
            1: return "\r";
            default: return "\r\n";
        endcase
    endfunction

    task automatic add_rand_value(int n, bit digits);
        for (int i = 0; i < n; i++) begin
            if (digits) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
            else begin
                logic [7:0] b;
                b = 8'($urandom);
                if (b == CH_CR || b == CH_LF) b = 8'h41;
                add_byte(b);
            end
        end
    endtask

    task automatic add_rand_line();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            add_str($urandom_range(0, 1) ? "data: " : "data:");
            add_rand_value($urandom_range(0, 6), 0);
        end else if (sel < 42) begin
            add_str("event:"); add_rand_value($urandom_range(0, 5), 0);
        end else if (sel < 54) begin
            add_str("id: "); add_rand_value($urandom_range(0, 4), 0);
        end else if (sel < 66) begin
            add_str("retry: ");
            add_rand_value($urandom_range(0, 21), $urandom_range(0, 5) != 0);
        end else if (sel < 74) begin
            add_str(":"); add_rand_value($urandom_range(0, 5), 0);
        end else if (sel < 80) begin
            case ($urandom_range(0, 3))
                0: add_str("data");
                1: add_str("event");
                2: add_str("id");
                default: add_str("retry");
            endcase
        end else if (sel < 86) begin
            add_rand_value($urandom_range(1, 6), 0);
        end
        // else blank line
        add_str(rand_eol());
    endtask

    task automatic drain_wait();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // sender: bursts and gaps
    task automatic send_all();
        int burst;
        while (stim.size() != 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && stim.size() != 0) begin
                if (requests_sent == 150 && !stall_pause_done) begin
                    stall_pause_done = 1;
                    req_if.valid <= 0;
                    drain_wait();
                    @(negedge i_clk);
                end
                req_if.valid <= 1;
                req_if.stream_byte <= stim[0];
                @(posedge i_clk);
                while (!req_if.ready) @(posedge i_clk);
                sb.note_byte(stim.pop_front());
                requests_sent++;
                burst--;
                @(negedge i_clk);
            end
            if (stim.size() != 0 && $urandom_range(0, 2) == 0) begin
                req_if.valid <= 0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        req_if.valid <= 0;
    endtask

    initial begin
        int cyc;
        cyc = 0;
        tok_if.ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_off_rx) tok_if.ready <= 0;
            else if ((cyc / 64) % 3 == 0) tok_if.ready <= 1;
            else tok_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        t_tok_exp g;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && tok_if.valid && tok_if.ready) begin
                g = '{kind: tok_if.token_kind, tbyte: tok_if.token_byte,
                      flag: tok_if.token_flag, rp: tok_if.retry_present,
                      rv: tok_if.retry_value, last: tok_if.last_of_run};
                sb.check_token(g);
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        repeat (40) @(negedge i_clk);
        hold_off_rx = 1;
        repeat (60) @(negedge i_clk);
        hold_off_rx = 0;
    end

    initial begin
        sb = new();
        i_rst_n = 0;
        req_if.valid = 0;
        req_if.stream_byte = 0;
        // directed: partial BOM, id NUL, overflow, CRLF, comment, missing colon
        add_byte(8'hEF); add_byte(8'hBB);
        add_str("x\n");
        add_str("data\r\n");
        add_str("data:  a\r");
        add_str("\nid\n");
        add_byte(8'hFF);
        add_str(":c\n");
        add_str("id:a"); add_byte(8'h00); add_str("\n");
        add_str("retry:18446744073709551615\n");
        add_str("event\n\n");
        add_str("retry:18446744073709551616\n");
        add_str("retry: 12x\nretry\ndata:\n\r\n");
        while (stim.size() < 300) add_rand_line();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);
        send_all();
        drain_wait();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d stream bytes (BOM, CR/LF/CRLF, comments, all fields, retry overflow);",
                 requests_sent);
        $display("checked %0d tokens with stalls and a full-queue hold-off.", sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("sse_event_stream_tokenizer_core_test OK");
        else
            $display("sse_event_stream_tokenizer_core_test NOT OK");
        $finish;
    end
endmodule
